// File: rtl/yiqnpc_pkg.sv
// Shared types, sizes and YIQ coefficients for the nearest palette colour block.
// Depends on nothing; every other file imports it.
package yiqnpc_pkg;

   // palette depth and derived widths
   localparam int MAX_PALETTE = 256;
   localparam int IDX_W       = $clog2(MAX_PALETTE);
   localparam int CNT_W       = $clog2(MAX_PALETTE + 1);

   localparam int SIZE_W      = 9;
   localparam int COLOUR_W    = 8;
   localparam int ENTRY_W     = 3 * COLOUR_W;

   // arithmetic widths: differences, products, YIQ sums, magnitudes, squares, total
   localparam int DIFF_W      = COLOUR_W + 1;
   localparam int COEF_W      = 15;
   localparam int PROD_W      = 23;
   localparam int SUM_W       = 24;
   localparam int MAG_W       = SUM_W - 1;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int TOT_W       = SQ_W + 2;
   localparam int DIST_SHIFT  = 28;
   localparam int DIST_W      = 18;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

   // function codes
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // YIQ coefficients scaled by 2^14 (magnitudes; signs applied in the sums)
   localparam logic signed [COEF_W-1:0] CY_R = 15'sd4899;
   localparam logic signed [COEF_W-1:0] CY_G = 15'sd9617;
   localparam logic signed [COEF_W-1:0] CY_B = 15'sd1868;
   localparam logic signed [COEF_W-1:0] CI_R = 15'sd9760;
   localparam logic signed [COEF_W-1:0] CI_G = 15'sd4497;
   localparam logic signed [COEF_W-1:0] CI_B = 15'sd5264;
   localparam logic signed [COEF_W-1:0] CQ_R = 15'sd3464;
   localparam logic signed [COEF_W-1:0] CQ_G = 15'sd8562;
   localparam logic signed [COEF_W-1:0] CQ_B = 15'sd5098;

   typedef struct packed {
      logic                func;
      logic [7:0]          entry_index;
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [7:0]        best_index;
      logic [DIST_W-1:0] best_distance;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic             wr_en;
      logic             start;
      logic             issue;
      logic [IDX_W-1:0] rd_addr;
      logic             load_rsp;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic busy;
   } dp_status_type;

endpackage

// File: rtl/yiqnpc_ctrl.sv
// Controller for the nearest palette colour block: handshakes, size register, search sequencing.
// Depends on yiqnpc_pkg.
module yiqnpc_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  yiqnpc_pkg::req_type               req_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [yiqnpc_pkg::SIZE_W-1:0]     csr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output yiqnpc_pkg::dp_cmd_type            cmd,
   input  yiqnpc_pkg::dp_status_type         status
);
   import yiqnpc_pkg::*;

   state_type          state_ff, state_in;
   logic [SIZE_W-1:0]  size_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   n_eff;
   logic               req_xfer;
   logic               last_issue;
   logic               out_free;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // clamp the searched count to 1 .. MAX_PALETTE
   always_comb begin
      if (size_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (size_ff > SIZE_W'(MAX_PALETTE)) begin
         n_eff = CNT_W'(MAX_PALETTE);
      end else begin
         n_eff = CNT_W'(size_ff);
      end
   end

   assign last_issue = (count_ff == n_eff - CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         size_ff <= csr_data;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_data.func == FUNC_QUERY) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.rd_addr  = count_ff[IDX_W-1:0];
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            count_in  = '0;
            // ready is high throughout idle, so valid alone marks the transfer
            if (req_valid) begin
               cmd.wr_en = (req_data.func == FUNC_LOAD) &&
                           ({1'b0, req_data.entry_index} < 9'(MAX_PALETTE));
               cmd.start = (req_data.func == FUNC_QUERY);
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            count_in  = count_ff + CNT_W'(1);
         end
         ST_DRAIN: begin
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/yiqnpc_datapath.sv
// Datapath: palette memory, pipelined YIQ distance, running minimum and result register.
// Depends on yiqnpc_pkg.
module yiqnpc_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  yiqnpc_pkg::req_type         req_data,
   input  yiqnpc_pkg::dp_cmd_type      cmd,
   output yiqnpc_pkg::dp_status_type   status,
   output yiqnpc_pkg::rsp_type         rsp_data
);
   import yiqnpc_pkg::*;

   localparam int NSTAGE = 7;

   logic [ENTRY_W-1:0]             mem [MAX_PALETTE];
   logic [ENTRY_W-1:0]             rd_data_ff;
   logic [COLOUR_W-1:0]            qr_ff, qg_ff, qb_ff;
   logic [NSTAGE-1:0]              v_ff;
   logic [IDX_W-1:0]               idx_ff [NSTAGE];
   logic signed [DIFF_W-1:0]       dr_ff, dg_ff, db_ff;
   logic signed [PROD_W-1:0]       prod_ff [9];
   logic signed [SUM_W-1:0]        dy_ff, di_ff, dq_ff;
   logic [MAG_W-1:0]               my_ff, mi_ff, mq_ff;
   logic [SQ_W-1:0]                sy_ff, si_ff, sq_ff;
   logic [TOT_W-1:0]               tot_ff;
   logic                           have_ff;
   logic [TOT_W-1:0]               best_sum_ff;
   logic [IDX_W-1:0]               best_idx_ff;
   logic [TOT_W-1:0]               rounded;
   logic [TOT_W-DIST_SHIFT-1:0]    dist_full;
   logic [DIST_W-1:0]              dist_sat;
   rsp_type                        rsp_ff;

   assign status.busy = |v_ff;
   assign rsp_data    = rsp_ff;

   // palette memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[req_data.entry_index[IDX_W-1:0]] <= {req_data.red, req_data.green, req_data.blue};
      end
      if (cmd.issue) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         qr_ff <= req_data.red;
         qg_ff <= req_data.green;
         qb_ff <= req_data.blue;
      end
   end

   // stage valids and the entry index travelling alongside
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[NSTAGE-2:0], cmd.issue};
      end
   end

   always_ff @(posedge clock) begin
      idx_ff[0] <= cmd.rd_addr;
      for (int s = 1; s < NSTAGE; s++) begin
         idx_ff[s] <= idx_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      // differences, query minus entry
      dr_ff <= $signed({1'b0, qr_ff}) - $signed({1'b0, rd_data_ff[23:16]});
      dg_ff <= $signed({1'b0, qg_ff}) - $signed({1'b0, rd_data_ff[15:8]});
      db_ff <= $signed({1'b0, qb_ff}) - $signed({1'b0, rd_data_ff[7:0]});
      // constant products
      prod_ff[0] <= PROD_W'(dr_ff) * PROD_W'(CY_R);
      prod_ff[1] <= PROD_W'(dg_ff) * PROD_W'(CY_G);
      prod_ff[2] <= PROD_W'(db_ff) * PROD_W'(CY_B);
      prod_ff[3] <= PROD_W'(dr_ff) * PROD_W'(CI_R);
      prod_ff[4] <= PROD_W'(dg_ff) * PROD_W'(CI_G);
      prod_ff[5] <= PROD_W'(db_ff) * PROD_W'(CI_B);
      prod_ff[6] <= PROD_W'(dr_ff) * PROD_W'(CQ_R);
      prod_ff[7] <= PROD_W'(dg_ff) * PROD_W'(CQ_G);
      prod_ff[8] <= PROD_W'(db_ff) * PROD_W'(CQ_B);
      // YIQ differences
      dy_ff <= SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2]);
      di_ff <= SUM_W'(prod_ff[3]) - SUM_W'(prod_ff[4]) - SUM_W'(prod_ff[5]);
      dq_ff <= SUM_W'(prod_ff[6]) - SUM_W'(prod_ff[7]) + SUM_W'(prod_ff[8]);
      // magnitudes
      my_ff <= MAG_W'(dy_ff < 0 ? -dy_ff : dy_ff);
      mi_ff <= MAG_W'(di_ff < 0 ? -di_ff : di_ff);
      mq_ff <= MAG_W'(dq_ff < 0 ? -dq_ff : dq_ff);
      // squares
      sy_ff <= SQ_W'(my_ff) * SQ_W'(my_ff);
      si_ff <= SQ_W'(mi_ff) * SQ_W'(mi_ff);
      sq_ff <= SQ_W'(mq_ff) * SQ_W'(mq_ff);
      // full sum of squares
      tot_ff <= TOT_W'(sy_ff) + TOT_W'(si_ff) + TOT_W'(sq_ff);
   end

   // running minimum; strict compare keeps the earliest index on a tie
   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else if (cmd.start) begin
         have_ff <= 1'b0;
      end else if (v_ff[NSTAGE-1]) begin
         have_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (v_ff[NSTAGE-1] && (!have_ff || tot_ff < best_sum_ff)) begin
         best_sum_ff <= tot_ff;
         best_idx_ff <= idx_ff[NSTAGE-1];
      end
   end

   always_comb begin
      rounded   = best_sum_ff + (TOT_W'(1) << (DIST_SHIFT - 1));
      dist_full = rounded[TOT_W-1:DIST_SHIFT];
      if (dist_full > (TOT_W-DIST_SHIFT)'({DIST_W{1'b1}})) begin
         dist_sat = {DIST_W{1'b1}};
      end else begin
         dist_sat = dist_full[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.best_index    <= 8'(best_idx_ff);
         rsp_ff.best_distance <= dist_sat;
      end
   end

endmodule

// File: rtl/yiq_nearest_palette_color.sv
// Top level of the nearest palette colour block under a YIQ squared distance.
// Depends on yiqnpc_pkg, yiqnpc_ctrl and yiqnpc_datapath.
//
// Usage:
//   req_*  : one transfer per item. func selects a palette load (writes entry_index with
//            red/green/blue, no result) or a query (searches the palette for the colour).
//   rsp_*  : one transfer per query: best_index and the rounded best_distance.
//   csr_*  : write the search size (9 bits); always ready, write only while idle.
// Timing:
//   A load writes the palette at its transfer; the next item may follow at once.
//   A query (search size clamped to 1 .. MAX_PALETTE) raises rsp_valid once the memory read
//   port has handed out one entry a cycle, the seven-stage distance pipeline has drained,
//   the minimum has settled and the result register has loaded; req_ready returns in the
//   same cycle as rsp_valid.
//   The block works on one query at a time; req_ready is high only between queries.
// Reset:
//   Synchronous, active high. Clears the sequencer, the pipeline valids and rsp_valid and
//   sets the search size to 16. The palette store is not cleared; load every entry a query
//   will search before the first query.
// Stalls:
//   A result holds in the output register while rsp_ready is low; further loads and a new
//   query are taken meanwhile, and a finished query waits until the register frees.
module yiq_nearest_palette_color (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  yiqnpc_pkg::req_type           req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output yiqnpc_pkg::rsp_type           rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [yiqnpc_pkg::SIZE_W-1:0] csr_data
);
   import yiqnpc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencing, handshakes and the size register
   yiqnpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // palette store, distance pipeline, minimum search and output register
   yiqnpc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
